FILE: hw/rtl/pbk_pkg.sv
package pbk_pkg;

  localparam int PW_DEPTH   = 128;
  localparam int SALT_DEPTH = 256;

  localparam logic [7:0] PW_FULL   = 8'd128;
  localparam logic [8:0] SALT_FULL = 9'd256;
  localparam logic [9:0] KEY_MAX   = 10'd512;

  localparam logic [1:0] ACT_PW     = 2'd0;
  localparam logic [1:0] ACT_SALT   = 2'd1;
  localparam logic [1:0] ACT_DERIVE = 2'd2;

  localparam logic REG_ITER = 1'b0;
  localparam logic REG_KLEN = 1'b1;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;

  typedef enum logic [2:0] {
    J_PWHASH, J_IPAD, J_OPAD, J_U1IN, J_UIN, J_OUT
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FEED, S_COMP, S_WAIT, S_JOBEND, S_EMIT
  } state_t;

  typedef struct packed {
    logic         start;
    logic [255:0] h_init;
    logic [511:0] blk;
  } sha_req_t;

  typedef struct packed {
    logic         done;
    logic [255:0] h;
  } sha_rsp_t;

endpackage

FILE: hw/rtl/pbk_sha_core.sv
module pbk_sha_core import pbk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sha_req_t req,
  output sha_rsp_t rsp
);

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [255:0] hin_r;
  logic [5:0]  rnd_r;
  logic        run_r;
  logic        done_r;

  logic [31:0] t1, t2, wn, bs0, bs1, ss0, ss1, ch, mj;

  always_comb begin
    bs1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    bs0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + bs1 + ch + SHA_K[rnd_r] + w_r[0];
    t2  = bs0 + mj;
    ss0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    ss1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn  = w_r[0] + ss0 + w_r[9] + ss1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hin_r <= req.h_init;
      for (int i = 0; i < 8; i++) v_r[i] <= req.h_init[255 - 32 * i -: 32];
      for (int i = 0; i < 16; i++) w_r[i] <= req.blk[511 - 32 * i -: 32];
    end else if (run_r) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wn;
    end
  end

  always_comb begin
    rsp.done = done_r;
    for (int i = 0; i < 8; i++) rsp.h[255 - 32 * i -: 32] = hin_r[255 - 32 * i -: 32] + v_r[i];
  end

endmodule

FILE: hw/rtl/pbkdf2_hmac_sha256_engine.sv
// PBKDF2 engine with HMAC-SHA256. Password and salt bytes load at one request per cycle while
// the block is idle. A derive request keeps the block busy: each SHA-256 compression gathers
// its 64-byte block a byte at a time, waiting on the store read port for each byte, then runs
// through the single round unit. A derive costs 2 compressions for the key pads
// (plus ceil((pw+9)/64) when the password exceeds 64 bytes) and, per 32-byte output block,
// ceil((salt+13)/64) + 1 + 2 * (iteration_count - 1) compressions, then up to four
// result words per block, one a cycle while out_ready holds. Store overflow or a zero key
// length gives one empty word at once.
module pbkdf2_hmac_sha256_engine import pbk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_key_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic        out_error,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [7:0] byte_of(input logic [255:0] v, input logic [4:0] idx);
    byte_of = v[8'd255 - {idx, 3'b000} -: 8];
  endfunction

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic   job_go;

  logic [8:0]   pos_r;
  logic         ph_r;
  logic [511:0] blk_r;
  logic [255:0] hcur_r, imid_r, omid_r, chain_r, dig_r, acc_r;
  logic [31:0]  bn_r;
  logic [30:0]  it_r, iters_r, iter_cfg_r;
  logic [9:0]   len_r, off_r, klen_r;
  logic [1:0]   wsel_r;
  logic [7:0]   pw_cnt_r;
  logic [8:0]   salt_cnt_r;
  logic         ovf_r;

  logic [7:0] pw_mem [PW_DEPTH];
  logic [7:0] salt_mem [SALT_DEPTH];
  logic [7:0] pw_rd_r, salt_rd_r;

  logic        out_valid_r, out_last_r, out_error_r;
  logic [63:0] out_word_r;
  logic [3:0]  out_cnt_r;

  sha_req_t req;
  sha_rsp_t rsp;

  pbk_sha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // request decode
  logic       in_acc, emit_ok, hashed, err_path, last_word, out_set;
  logic [9:0] len_c, rem;
  logic [3:0] n_bytes;
  logic [63:0] word_c, mask_c;

  assign hashed  = pw_cnt_r > 8'd64;
  assign emit_ok = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && (in_action != ACT_DERIVE || emit_ok);
  assign in_acc  = in_valid && in_ready;
  assign len_c   = (klen_r > KEY_MAX) ? KEY_MAX : klen_r;
  assign err_path = ovf_r || (len_c == 10'd0);
  assign out_set = (state_r == S_EMIT && emit_ok) ||
                   (in_acc && in_action == ACT_DERIVE && err_path);

  assign rem       = len_r - off_r;
  assign last_word = rem <= 10'd8;
  assign n_bytes   = last_word ? rem[3:0] : 4'd8;
  assign mask_c    = (n_bytes == 4'd8) ? {64{1'b1}} : ~({64{1'b1}} >> {n_bytes[2:0], 3'b000});
  assign word_c    = acc_r[8'd255 - {wsel_r, 6'b000000} -: 64] & mask_c;

  // message byte generator
  logic [8:0]  msg_len, pend, pend_sum, lidx, bq;
  logic        padded, base64;
  logic [15:0] bitlen;
  logic [7:0]  data_b, fbyte, pad_b;

  always_comb begin
    padded = 1'b1;
    base64 = 1'b1;
    msg_len = 9'd32;
    pad_b = (job_r == J_IPAD) ? IPAD_BYTE : OPAD_BYTE;
    bq = pos_r - salt_cnt_r;
    data_b = byte_of(dig_r, pos_r[4:0]);
    case (job_r)
      J_PWHASH: begin
        base64 = 1'b0;
        msg_len = {1'b0, pw_cnt_r};
        data_b = pw_rd_r;
      end
      J_IPAD, J_OPAD: begin
        padded = 1'b0;
        msg_len = 9'd64;
        if (hashed) begin
          data_b = (pos_r < 9'd32) ? byte_of(chain_r, pos_r[4:0]) : 8'h00;
        end else begin
          data_b = (pos_r < {1'b0, pw_cnt_r}) ? pw_rd_r : 8'h00;
        end
        data_b = data_b ^ pad_b;
      end
      J_U1IN: begin
        msg_len = salt_cnt_r + 9'd4;
        data_b = (pos_r < salt_cnt_r) ? salt_rd_r : bn_r[5'd31 - {bq[1:0], 3'b000} -: 8];
      end
      J_UIN: data_b = byte_of(chain_r, pos_r[4:0]);
      J_OUT: data_b = byte_of(dig_r, pos_r[4:0]);
      default: data_b = 8'h00;
    endcase
    pend_sum = msg_len + 9'd72;
    pend = padded ? {pend_sum[8:6], 6'b000000} : 9'd64;
    bitlen = {3'b000, {1'b0, msg_len} + (base64 ? 10'd64 : 10'd0), 3'b000};
    lidx = pos_r - pend + 9'd8;
    if (pos_r < msg_len) begin
      fbyte = data_b;
    end else if (pos_r == msg_len) begin
      fbyte = 8'h80;
    end else if (pos_r >= pend - 9'd8) begin
      fbyte = (lidx[2:0] == 3'd6) ? bitlen[15:8] : (lidx[2:0] == 3'd7) ? bitlen[7:0] : 8'h00;
    end else begin
      fbyte = 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    job_go = 1'b0;
    req.start = 1'b0;
    req.h_init = hcur_r;
    req.blk = blk_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_action == ACT_DERIVE && !err_path) begin
          job_go = 1'b1;
          job_nxt = hashed ? J_PWHASH : J_IPAD;
        end
      end
      S_FEED: begin
        if (ph_r && pos_r[5:0] == 6'd63) state_nxt = S_COMP;
      end
      S_COMP: begin
        req.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) state_nxt = (pos_r == pend) ? S_JOBEND : S_FEED;
      end
      S_JOBEND: begin
        job_go = 1'b1;
        case (job_r)
          J_PWHASH: job_nxt = J_IPAD;
          J_IPAD:   job_nxt = J_OPAD;
          J_OPAD:   job_nxt = J_U1IN;
          J_U1IN:   job_nxt = J_OUT;
          J_UIN:    job_nxt = J_OUT;
          J_OUT: begin
            if (it_r == iters_r) begin
              job_go = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              job_nxt = J_UIN;
            end
          end
          default: job_nxt = J_IPAD;
        endcase
      end
      S_EMIT: begin
        if (emit_ok) begin
          if (last_word) begin
            state_nxt = S_IDLE;
          end else if (wsel_r == 2'd3) begin
            job_go = 1'b1;
            job_nxt = J_U1IN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (job_go) state_nxt = S_FEED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r <= J_IPAD;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_rd_r <= pw_mem[pos_r[6:0]];
    salt_rd_r <= salt_mem[pos_r[7:0]];
    if (in_acc && in_action == ACT_PW && pw_cnt_r < PW_FULL) pw_mem[pw_cnt_r[6:0]] <= in_data_byte;
    if (in_acc && in_action == ACT_SALT && salt_cnt_r < SALT_FULL) begin
      salt_mem[salt_cnt_r[7:0]] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cfg_r <= 31'd1;
      klen_r <= 10'd32;
      pw_cnt_r <= '0;
      salt_cnt_r <= '0;
      ovf_r <= 1'b0;
      bn_r <= 32'd1;
      ph_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ITER) iter_cfg_r <= cfg_wdata;
        else klen_r <= cfg_wdata[9:0];
      end
      if (out_valid_r && out_ready && !out_set) out_valid_r <= 1'b0;

      if (in_acc) begin
        case (in_action)
          ACT_PW: begin
            if (pw_cnt_r < PW_FULL) pw_cnt_r <= pw_cnt_r + 8'd1;
            else ovf_r <= 1'b1;
          end
          ACT_SALT: begin
            if (salt_cnt_r < SALT_FULL) salt_cnt_r <= salt_cnt_r + 9'd1;
            else ovf_r <= 1'b1;
          end
          ACT_DERIVE: begin
            if (err_path) begin
              out_valid_r <= 1'b1;
              out_word_r <= '0;
              out_cnt_r <= '0;
              out_last_r <= 1'b1;
              out_error_r <= ovf_r;
              pw_cnt_r <= '0;
              salt_cnt_r <= '0;
              ovf_r <= 1'b0;
            end else begin
              len_r <= len_c;
              iters_r <= (iter_cfg_r == 31'd0) ? 31'd1 : iter_cfg_r;
              bn_r <= 32'd1;
              off_r <= '0;
              wsel_r <= '0;
            end
          end
          default: ;
        endcase
      end

      if (job_go) begin
        pos_r <= '0;
        ph_r <= 1'b0;
        case (job_nxt)
          J_U1IN, J_UIN: hcur_r <= imid_r;
          J_OUT:         hcur_r <= omid_r;
          default:       hcur_r <= SHA_IV;
        endcase
      end else begin
        case (state_r)
          S_FEED: begin
            ph_r <= !ph_r;
            // store read data is valid in the cycle after the address moves
            if (ph_r) begin
              blk_r <= {blk_r[503:0], fbyte};
              pos_r <= pos_r + 9'd1;
            end
          end
          S_WAIT: begin
            if (rsp.done) hcur_r <= rsp.h;
          end
          default: ;
        endcase
      end

      if (state_r == S_JOBEND) begin
        case (job_r)
          J_PWHASH: chain_r <= hcur_r;
          J_IPAD:   imid_r <= hcur_r;
          J_OPAD:   omid_r <= hcur_r;
          J_U1IN: begin
            dig_r <= hcur_r;
            it_r <= 31'd1;
          end
          J_UIN:    dig_r <= hcur_r;
          J_OUT: begin
            chain_r <= hcur_r;
            acc_r <= (it_r == 31'd1) ? hcur_r : (acc_r ^ hcur_r);
            if (it_r != iters_r) it_r <= it_r + 31'd1;
          end
          default: ;
        endcase
      end

      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
        out_word_r <= word_c;
        out_cnt_r <= n_bytes;
        out_last_r <= last_word;
        out_error_r <= 1'b0;
        off_r <= off_r + {6'd0, n_bytes};
        wsel_r <= wsel_r + 2'd1;
        if (last_word) begin
          pw_cnt_r <= '0;
          salt_cnt_r <= '0;
        end else if (wsel_r == 2'd3) begin
          bn_r <= bn_r + 32'd1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_key_word = out_word_r;
  assign out_byte_count = out_cnt_r;
  assign out_last = out_last_r;
  assign out_error = out_error_r;

endmodule

FILE: hw/rtl/pbk_chk.sv
module pbk_chk import pbk_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_byte_count,
  input logic        out_last,
  input logic        out_error
);

  // a pending result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a derive request either answers at once or makes the block busy
  a_derive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_DERIVE |=> !in_ready || out_valid)
    else $error("derive request left block idle");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_byte_count == 4'd0 && out_last)
    else $error("error result malformed");

  // an empty word only ever closes a derive
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count <= 4'd8 && (out_byte_count != 4'd0 || out_last))
    else $error("byte count out of range");

endmodule

bind pbkdf2_hmac_sha256_engine pbk_chk u_pbk_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte_count (out_byte_count),
  .out_last       (out_last),
  .out_error      (out_error)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pbk_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam bit [255:0] SHA_IV =
    256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;
  localparam bit [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef bit [7:0] octet_q[$];

  typedef struct packed {
    bit [63:0] word;
    bit [3:0]  cnt;
    bit        last;
    bit        err;
  } key_word_t;

  typedef struct packed {
    bit        is_cfg;
    bit [1:0]  act;
    bit [30:0] val;
    bit        typed;
    key_word_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_key_word;
  logic [3:0]  out_byte_count;
  logic        out_last;
  logic        out_error;
  logic        cfg_we;
  logic        cfg_index;
  logic [30:0] cfg_wdata;

  pbkdf2_hmac_sha256_engine dut (.*);

  // predictor state
  octet_q      pw_bytes;
  octet_q      salt_bytes;
  bit          store_ovf;
  bit [30:0]   iter_reg;
  bit [9:0]    klen_reg;
  bit [255:0]  inner_mid;
  bit [255:0]  outer_mid;
  key_word_t   key_words_due[$];
  int          n_items;
  int          n_fail;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic bit [31:0] ror(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic bit [255:0] sha_block(bit [255:0] hin, bit [511:0] blk);
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = hin;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {a + hin[255:224], b + hin[223:192], c + hin[191:160], d + hin[159:128],
            e + hin[127:96], f + hin[95:64], g + hin[63:32], h + hin[31:0]};
  endfunction

  // hash msg starting from midstate hin, with done bytes already absorbed
  function automatic bit [255:0] sha_tail(bit [255:0] hin, int done, octet_q msg);
    octet_q     m;
    bit [511:0] blk;
    bit [63:0]  nbits;
    bit [255:0] hh;
    m = msg;
    nbits = 64'(done + msg.size()) << 3;
    m.push_back(8'h80);
    while (m.size() % 64 != 56) m.push_back(8'h00);
    for (int i = 0; i < 8; i++) m.push_back(nbits[63 - 8 * i -: 8]);
    hh = hin;
    for (int o = 0; o < m.size(); o += 64) begin
      for (int j = 0; j < 64; j++) blk[511 - 8 * j -: 8] = m[o + j];
      hh = sha_block(hh, blk);
    end
    return hh;
  endfunction

  function automatic octet_q digest_octets(bit [255:0] dg);
    octet_q q;
    for (int i = 0; i < 32; i++) q.push_back(dg[255 - 8 * i -: 8]);
    return q;
  endfunction

  function automatic bit [255:0] hmac(octet_q msg);
    return sha_tail(outer_mid, 64, digest_octets(sha_tail(inner_mid, 64, msg)));
  endfunction

  function automatic void derive_key(bit record);
    int         len;
    int         iters;
    int         n;
    bit [511:0] hkey;
    bit [255:0] u, acc;
    bit [31:0]  blk_no;
    octet_q     msg;
    octet_q     kb;
    key_word_t  kw;
    len = (klen_reg > KEY_MAX) ? int'(KEY_MAX) : int'(klen_reg);
    if (store_ovf || len == 0) begin
      kw = '{word: 64'd0, cnt: 4'd0, last: 1'b1, err: store_ovf};
      if (record) key_words_due.push_back(kw);
    end else begin
      iters = (iter_reg == 0) ? 1 : int'(iter_reg);
      hkey = '0;
      // long passwords are hashed down to the key
      if (pw_bytes.size() > 64) hkey[511 -: 256] = sha_tail(SHA_IV, 0, pw_bytes);
      else for (int i = 0; i < pw_bytes.size(); i++) hkey[511 - 8 * i -: 8] = pw_bytes[i];
      inner_mid = sha_block(SHA_IV, hkey ^ {64{IPAD_BYTE}});
      outer_mid = sha_block(SHA_IV, hkey ^ {64{OPAD_BYTE}});
      blk_no = 1;
      while (kb.size() < len) begin
        msg = salt_bytes;
        for (int i = 0; i < 4; i++) msg.push_back(blk_no[31 - 8 * i -: 8]);
        u = hmac(msg);
        acc = u;
        for (int i = 1; i < iters; i++) begin
          u = hmac(digest_octets(u));
          acc ^= u;
        end
        for (int j = 0; j < 32; j++) if (kb.size() < len) kb.push_back(acc[255 - 8 * j -: 8]);
        blk_no++;
      end
      for (int off = 0; off < len; off += 8) begin
        n = (len - off > 8) ? 8 : len - off;
        kw = '0;
        for (int j = 0; j < n; j++) kw.word[63 - 8 * j -: 8] = kb[off + j];
        kw.cnt = 4'(n);
        kw.last = (off + n >= len);
        if (record) key_words_due.push_back(kw);
      end
    end
    pw_bytes.delete();
    salt_bytes.delete();
    store_ovf = 1'b0;
  endfunction

  function automatic void take_request(logic [1:0] act, logic [7:0] data, bit record);
    case (act)
      ACT_PW: begin
        if (pw_bytes.size() < PW_DEPTH) pw_bytes.push_back(data);
        else store_ovf = 1'b1;
      end
      ACT_SALT: begin
        if (salt_bytes.size() < SALT_DEPTH) salt_bytes.push_back(data);
        else store_ovf = 1'b1;
      end
      ACT_DERIVE: derive_key(record);
      default: ;
    endcase
    if (act != ACT_NONE) n_items++;
  endfunction

  task automatic send_request(logic [1:0] act, logic [7:0] data, bit record);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_data_byte = data;
    do @(posedge clk); while (!in_ready);
    take_request(act, data, record);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    wait (key_words_due.size() == 0);
    @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ITER) iter_reg = val;
    else klen_reg = val[9:0];
  endtask

  // result checker
  always @(posedge clk) begin
    key_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (key_words_due.size() == 0) begin
        $display("%0t: unexpected key word %h", $time, out_key_word);
        n_fail++;
      end else begin
        w = key_words_due.pop_front();
        if (out_key_word !== w.word) begin
          $display("%0t: key_word exp %h got %h", $time, w.word, out_key_word);
          n_fail++;
        end
        if (out_byte_count !== w.cnt) begin
          $display("%0t: byte_count exp %0d got %0d", $time, w.cnt, out_byte_count);
          n_fail++;
        end
        if (out_last !== w.last) begin
          $display("%0t: last exp %0d got %0d", $time, w.last, out_last);
          n_fail++;
        end
        if (out_error !== w.err) begin
          $display("%0t: error exp %0d got %0d", $time, w.err, out_error);
          n_fail++;
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 9) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic stim_row_t item_row(logic [1:0] act, logic [7:0] data);
    return '{is_cfg: 1'b0, act: act, val: 31'(data), typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [30:0] val);
    return '{is_cfg: 1'b1, act: {1'b0, idx}, val: val, typed: 1'b0, want: '0};
  endfunction

  initial begin
    stim_row_t   rows[$];
    stim_row_t   r;
    int          seq;
    int          pw_n, salt_n, p, s;
    logic [30:0] v;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_PW;
    in_data_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = REG_ITER;
    cfg_wdata = '0;
    n_items = 0;
    n_fail = 0;
    quiet = 1'b0;
    store_ovf = 1'b0;
    iter_reg = 31'd1;
    klen_reg = 10'd32;

    // empty password and salt with reset settings
    rows.push_back(item_row(ACT_DERIVE, 8'h00));
    rows.push_back(item_row(ACT_PW, 8'h00));
    rows.push_back(item_row(ACT_PW, 8'hff));
    rows.push_back(item_row(ACT_SALT, 8'h00));
    rows.push_back(item_row(ACT_SALT, 8'hff));
    rows.push_back(item_row(ACT_NONE, 8'ha5));
    rows.push_back(item_row(ACT_DERIVE, 8'hff));
    // zero key length: a single empty word
    rows.push_back(cfg_row(REG_KLEN, 31'd0));
    rows.push_back(item_row(ACT_PW, 8'h5a));
    r = item_row(ACT_DERIVE, 8'h00);
    r.typed = 1'b1;
    r.want = '{word: 64'd0, cnt: 4'd0, last: 1'b1, err: 1'b0};
    rows.push_back(r);
    // largest count overwritten by zero, which counts as one; key length saturates
    rows.push_back(cfg_row(REG_ITER, 31'h7fffffff));
    rows.push_back(cfg_row(REG_ITER, 31'd0));
    rows.push_back(cfg_row(REG_KLEN, 31'h3ff));
    rows.push_back(item_row(ACT_SALT, 8'h01));
    rows.push_back(item_row(ACT_DERIVE, 8'h00));
    rows.push_back(cfg_row(REG_KLEN, 31'd1));
    rows.push_back(cfg_row(REG_ITER, 31'd2));
    rows.push_back(item_row(ACT_SALT, 8'h80));
    rows.push_back(item_row(ACT_DERIVE, 8'h00));
    rows.push_back(cfg_row(REG_KLEN, 31'd33));
    rows.push_back(item_row(ACT_DERIVE, 8'h00));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) write_reg(r.act[0], r.val);
      else begin
        send_request(r.act, r.val[7:0], !r.typed);
        if (r.typed) key_words_due.push_back(r.want);
      end
    end

    seq = 0;
    while (n_items < 170) begin
      if (n_items >= 140) quiet = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        p = $urandom_range(0, 9);
        v = (p == 0) ? 31'd0 : (p < 7) ? 31'd1 : 31'($urandom_range(2, 4));
        write_reg(REG_ITER, v);
      end
      if ($urandom_range(0, 1) == 1) begin
        p = $urandom_range(0, 19);
        v = (p == 0) ? 31'd0 : (p < 17) ? 31'($urandom_range(1, 64)) :
            (p < 19) ? 31'($urandom_range(65, 512)) : 31'($urandom_range(513, 1023));
        write_reg(REG_KLEN, v);
      end
      // the first sequence overflows the password store
      pw_n = (seq == 0) ? 129 : $urandom_range(0, 72);
      salt_n = $urandom_range(0, 8);
      p = 0;
      s = 0;
      while (p < pw_n || s < salt_n) begin
        if ($urandom_range(0, 19) == 0)
          send_request(ACT_NONE, 8'($urandom_range(0, 255)), 1'b1);
        else if (s >= salt_n || (p < pw_n && $urandom_range(0, 1) == 0)) begin
          send_request(ACT_PW, 8'($urandom_range(0, 255)), 1'b1);
          p++;
        end else begin
          send_request(ACT_SALT, 8'($urandom_range(0, 255)), 1'b1);
          s++;
        end
      end
      send_request(ACT_DERIVE, 8'($urandom_range(0, 255)), 1'b1);
      seq++;
    end

    wait (key_words_due.size() == 0);
    repeat (50) @(posedge clk);
    if (n_fail == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pbk_pkg.sv
hw/rtl/pbk_sha_core.sv
hw/rtl/pbkdf2_hmac_sha256_engine.sv
hw/rtl/pbk_chk.sv
bench/tb_top.sv
